[src/cmsc_pkg.sv]
// Shared types, constants and helpers of the completion match scorer.
package cmsc_pkg;

  // Byte and field widths
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned PLEN_W    = 5;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned SCORE_W   = 13;
  localparam int unsigned KIND_W    = 3;

  // Tier base scores, gap weight and the lower score limit
  localparam int unsigned SCORE_EXACT  = 1000;
  localparam int unsigned SCORE_PREFIX = 800;
  localparam int unsigned SCORE_WORD   = 600;
  localparam int unsigned SCORE_ANY    = 400;
  localparam int unsigned SCORE_SUBSEQ = 200;
  localparam int unsigned GAP_WEIGHT   = 10;
  localparam int          SCORE_MIN    = -4096;
  localparam int unsigned BASE_W       = 10;

  // Character codes used by case folding and word start detection
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  // Match tiers in priority order
  typedef enum logic [KIND_W-1:0] {
    KIND_EXACT  = 3'd0,
    KIND_PREFIX = 3'd1,
    KIND_WORD   = 3'd2,
    KIND_ANY    = 3'd3,
    KIND_SUBSEQ = 3'd4,
    KIND_NONE   = 3'd5
  } match_kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } reg_idx_e;

  // Per-cycle control broadcast along the cell row
  typedef struct packed {
    logic step;   // a real byte is taken this cycle
    logic clear;  // the item ends this cycle
  } cell_ctrl_t;

  // Fold a-z to upper case; other bytes pass unchanged
  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

[src/cmsc_cell.sv]
// One pattern position of the shift-and matcher row.
module cmsc_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cmsc_pkg::cell_ctrl_t              ctrl_i,
  input  logic [cmsc_pkg::CHAR_W-1:0]       char_i,      // folded candidate byte
  input  logic [cmsc_pkg::CHAR_W-1:0]       pat_i,       // raw pattern byte
  input  logic                              en_i,        // position lies inside the pattern
  input  logic                              tail_i,      // position is the last pattern byte
  input  logic                              prev_sub_i,
  input  logic                              prev_ws_i,
  output logic                              sub_o,
  output logic                              ws_o,
  output logic                              eq_o,
  output logic                              sub_hit_o,
  output logic                              ws_hit_o
);

  logic sub_q, sub_d;
  logic ws_q, ws_d;

  // Compare against the broadcast byte and extend the neighbour's partial match
  assign eq_o      = en_i && (cmsc_pkg::fold_char(pat_i) == char_i);
  assign sub_d     = prev_sub_i & eq_o;
  assign ws_d      = prev_ws_i & eq_o;
  assign sub_hit_o = tail_i & sub_d;
  assign ws_hit_o  = tail_i & ws_d;

  // Partial match bits, cleared at the end of every item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
      ws_q  <= 1'b0;
    end else if (ctrl_i.clear) begin
      sub_q <= 1'b0;
      ws_q  <= 1'b0;
    end else if (ctrl_i.step) begin
      sub_q <= sub_d;
      ws_q  <= ws_d;
    end
  end

  assign sub_o = sub_q;
  assign ws_o  = ws_q;

endmodule

[src/cmsc_score.sv]
// Result stages: holds the final item state, forms the tiered score and presents it.
module cmsc_score #(
  parameter int unsigned LEN_W = 8,
  parameter int unsigned EL_W  = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  cmsc_pkg::match_kind_e               in_kind_i,
  input  logic [LEN_W-1:0]                    in_len_i,
  input  logic [LEN_W-1:0]                    in_span_i,
  input  logic [EL_W-1:0]                     in_elen_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cmsc_pkg::SCORE_W-1:0] out_score_o,
  output cmsc_pkg::match_kind_e               out_kind_o,
  output logic                                out_cand_o
);

  localparam int unsigned GW = LEN_W + 2;
  localparam int unsigned TW = LEN_W + 4;
  localparam int unsigned SW = (LEN_W + 6 > 14) ? LEN_W + 6 : 14;

  logic                        snap_valid_q, snap_valid_d;
  cmsc_pkg::match_kind_e       snap_kind_q;
  logic [LEN_W-1:0]            snap_len_q;
  logic [LEN_W-1:0]            snap_span_q;
  logic [EL_W-1:0]             snap_elen_q;
  logic                        snap_adv;
  logic                        in_acc;

  logic                        out_valid_q, out_valid_d;
  logic signed [cmsc_pkg::SCORE_W-1:0] out_score_q;
  cmsc_pkg::match_kind_e       out_kind_q;
  logic                        out_cand_q;

  logic [GW-1:0]               gap_raw;
  logic [LEN_W-1:0]            gap_u;
  logic [cmsc_pkg::BASE_W-1:0] base_u;
  logic                        use_gap;
  logic                        use_len;
  logic [TW-1:0]               pen;
  logic signed [SW-1:0]        score_s;
  logic signed [SW-1:0]        score_sat;

  // Handshake between the snapshot stage and the output register
  assign snap_adv   = snap_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !snap_valid_q || snap_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    snap_valid_d = snap_valid_q;
    if (in_acc) begin
      snap_valid_d = 1'b1;
    end else if (snap_adv) begin
      snap_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (snap_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Gap of the subsequence match beyond a contiguous run, never negative
  assign gap_raw = {2'b00, snap_span_q} + GW'(1) - GW'(snap_elen_q);
  assign gap_u   = gap_raw[GW-1] ? '0 : gap_raw[LEN_W-1:0];

  // Tier base and which penalties apply
  always_comb begin
    base_u  = '0;
    use_gap = 1'b0;
    use_len = 1'b0;
    unique case (snap_kind_q)
      cmsc_pkg::KIND_EXACT: begin
        base_u = cmsc_pkg::BASE_W'(cmsc_pkg::SCORE_EXACT);
      end
      cmsc_pkg::KIND_PREFIX: begin
        base_u  = cmsc_pkg::BASE_W'(cmsc_pkg::SCORE_PREFIX);
        use_len = 1'b1;
      end
      cmsc_pkg::KIND_WORD: begin
        base_u  = cmsc_pkg::BASE_W'(cmsc_pkg::SCORE_WORD);
        use_len = 1'b1;
      end
      cmsc_pkg::KIND_ANY: begin
        base_u  = cmsc_pkg::BASE_W'(cmsc_pkg::SCORE_ANY);
        use_len = 1'b1;
      end
      cmsc_pkg::KIND_SUBSEQ: begin
        base_u  = cmsc_pkg::BASE_W'(cmsc_pkg::SCORE_SUBSEQ);
        use_gap = 1'b1;
        use_len = 1'b1;
      end
      default: begin
        base_u = '0;
      end
    endcase
  end

  // Score = base - weighted gap - length, limited below
  assign pen = (use_gap ? TW'(gap_u) * TW'(cmsc_pkg::GAP_WEIGHT) : '0)
             + (use_len ? TW'(snap_len_q) : '0);
  assign score_s   = $signed(SW'(base_u)) - $signed(SW'(pen));
  assign score_sat = (score_s < $signed(SW'(cmsc_pkg::SCORE_MIN)))
                   ? $signed(SW'(cmsc_pkg::SCORE_MIN)) : score_s;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      snap_kind_q <= in_kind_i;
      snap_len_q  <= in_len_i;
      snap_span_q <= in_span_i;
      snap_elen_q <= in_elen_i;
    end
    if (snap_adv) begin
      out_score_q <= score_sat[cmsc_pkg::SCORE_W-1:0];
      out_kind_q  <= snap_kind_q;
      out_cand_q  <= !score_sat[SW-1] && (score_sat != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_score_o = out_score_q;
  assign out_kind_o  = out_kind_q;
  assign out_cand_o  = out_cand_q;

endmodule

[src/completion_match_scorer.sv]
// Top level of the completion match scorer: configuration, cell row and item tracking.
//
//  channel   | direction | payload
//  ----------+-----------+-----------------------------------------------------------
//  s_axis    | in        | tdata: item_char; tuser: char_present; tlast: end_of_item
//  m_axis    | out       | tdata: match_score, match_kind; tuser: is_candidate
//  apb       | in / out  | 64-bit pattern registers at 0x00, 0x08, length at 0x10
//
// One byte is taken every cycle while s_axis_tready_o is high; each present byte steps
// the whole cell row once. The result of an item passes through the snapshot register
// and then the output register.
// Reset clears the pattern registers, the per-item state and both result stages.
// s_axis_tready_o falls only while both result stages hold an item and the
// downstream side does not take the output.
module completion_match_scorer #(
  parameter int unsigned PATTERN_MAX  = 16,
  parameter int unsigned ITEM_LEN_MAX = 255
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Candidate bytes
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] item_char
  input  logic [0:0]                     s_axis_tuser_i,  // [0] char_present
  input  logic                           s_axis_tlast_i,
  // Scores
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [15:0]                    m_axis_tdata_o,  // [12:0] match_score, [15:13] match_kind
  output logic [0:0]                     m_axis_tuser_o,  // [0] is_candidate
  // Configuration
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [cmsc_pkg::ADDR_W-1:0]    paddr_i,
  input  logic [cmsc_pkg::CFG_W-1:0]     pwdata_i,
  output logic [cmsc_pkg::CFG_W-1:0]     prdata_o,
  output logic                           pready_o
);

  localparam int unsigned NC = (PATTERN_MAX < cmsc_pkg::PAT_BYTES) ? PATTERN_MAX
                                                                   : cmsc_pkg::PAT_BYTES;
  localparam int unsigned EW = $clog2(NC + 1);
  localparam int unsigned LW = $clog2(ITEM_LEN_MAX + 1);

  // Configuration registers
  logic [cmsc_pkg::CFG_W-1:0]  pat_lo_q;
  logic [cmsc_pkg::CFG_W-1:0]  pat_hi_q;
  logic [cmsc_pkg::PLEN_W-1:0] plen_q;
  logic                        cfg_wr;
  cmsc_pkg::reg_idx_e          cfg_idx;
  logic [2*cmsc_pkg::CFG_W-1:0] pat_all;
  logic [EW-1:0]               elen;

  // Per-item state
  logic                        pal_q, pal_d;
  logic                        asep_q, asep_d;
  logic                        fany_q, fany_d;
  logic                        fws_q, fws_d;
  logic [LW-1:0]               len_q, len_d;
  logic [EW-1:0]               sidx_q, sidx_d;
  logic [LW-1:0]               first_q, first_d;
  logic [LW-1:0]               last_q, last_d;

  // Stream control
  logic                        in_acc;
  logic                        step;
  logic                        fin_ready;
  cmsc_pkg::cell_ctrl_t        ctrl;
  logic [cmsc_pkg::CHAR_W-1:0] char_f;

  // Cell row signals
  logic [NC-1:0]               sub_vec;
  logic [NC-1:0]               ws_vec;
  logic [NC-1:0]               eq_vec;
  logic [NC-1:0]               en_vec;
  logic [NC-1:0]               sub_hit_vec;
  logic [NC-1:0]               ws_hit_vec;
  logic [NC-1:0]               pos_sel_vec;
  logic [NC-1:0]               sidx_sel_vec;
  logic                        prefix_fail;
  logic                        ss_hit;

  // Final item summary
  cmsc_pkg::match_kind_e       fin_kind;
  logic [LW-1:0]               fin_span;

  cmsc_pkg::match_kind_e       out_kind;
  logic signed [cmsc_pkg::SCORE_W-1:0] out_score;
  logic                        out_cand;

  // Register port: writes on the access phase, reads combinational
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign cfg_idx  = cmsc_pkg::reg_idx_e'(paddr_i[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      plen_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cmsc_pkg::REG_PAT_LOW:  pat_lo_q <= pwdata_i;
        cmsc_pkg::REG_PAT_HIGH: pat_hi_q <= pwdata_i;
        cmsc_pkg::REG_PAT_LEN:  plen_q   <= pwdata_i[cmsc_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cmsc_pkg::REG_PAT_LOW:  prdata_o = pat_lo_q;
      cmsc_pkg::REG_PAT_HIGH: prdata_o = pat_hi_q;
      cmsc_pkg::REG_PAT_LEN:  prdata_o = cmsc_pkg::CFG_W'(plen_q);
      default:                prdata_o = '0;
    endcase
  end

  // Pattern length in use, limited to the cells present
  assign pat_all = {pat_hi_q, pat_lo_q};
  assign elen    = (plen_q > cmsc_pkg::PLEN_W'(NC)) ? EW'(NC) : EW'(plen_q);

  // Stream acceptance; every present byte steps the row, the last byte closes the item
  assign s_axis_tready_o = fin_ready;
  assign in_acc          = s_axis_tvalid_i && fin_ready;
  assign step            = in_acc && s_axis_tuser_i[0];
  assign ctrl.step       = step;
  assign ctrl.clear      = in_acc && s_axis_tlast_i;
  assign char_f          = cmsc_pkg::fold_char(s_axis_tdata_i);

  // Row of matcher cells; each takes its neighbour's partial match bit
  for (genvar j = 0; j < NC; j++) begin : g_cell
    logic prev_sub;
    logic prev_ws;

    if (j == 0) begin : g_head
      assign prev_sub = 1'b1;
      assign prev_ws  = asep_q;
    end else begin : g_link
      assign prev_sub = sub_vec[j-1];
      assign prev_ws  = ws_vec[j-1];
    end

    assign en_vec[j]       = EW'(j) < elen;
    assign pos_sel_vec[j]  = len_q == LW'(j);
    assign sidx_sel_vec[j] = sidx_q == EW'(j);

    cmsc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .char_i     (char_f),
      .pat_i      (pat_all[8*j +: 8]),
      .en_i       (en_vec[j]),
      .tail_i     (elen == EW'(j + 1)),
      .prev_sub_i (prev_sub),
      .prev_ws_i  (prev_ws),
      .sub_o      (sub_vec[j]),
      .ws_o       (ws_vec[j]),
      .eq_o       (eq_vec[j]),
      .sub_hit_o  (sub_hit_vec[j]),
      .ws_hit_o   (ws_hit_vec[j])
    );
  end

  // Prefix check at the current position and greedy subsequence step
  assign prefix_fail = |(pos_sel_vec & en_vec & ~eq_vec);
  assign ss_hit      = |(sidx_sel_vec & eq_vec);

  always_comb begin
    pal_d   = pal_q;
    asep_d  = asep_q;
    fany_d  = fany_q;
    fws_d   = fws_q;
    len_d   = len_q;
    sidx_d  = sidx_q;
    first_d = first_q;
    last_d  = last_q;
    if (step) begin
      pal_d  = pal_q && !prefix_fail;
      fany_d = fany_q || (|sub_hit_vec);
      fws_d  = fws_q || (|ws_hit_vec);
      asep_d = (char_f == cmsc_pkg::CHAR_SPACE) || (char_f == cmsc_pkg::CHAR_LPAREN);
      if (ss_hit) begin
        if (sidx_q == '0) begin
          first_d = len_q;
        end
        last_d = len_q;
        sidx_d = sidx_q + EW'(1);
      end
      if (len_q != LW'(ITEM_LEN_MAX)) begin
        len_d = len_q + LW'(1);
      end
    end
  end

  // Tier of the item as it stands after this byte
  always_comb begin
    if (pal_d && (len_d == LW'(elen))) begin
      fin_kind = cmsc_pkg::KIND_EXACT;
    end else if (pal_d && (len_d >= LW'(elen))) begin
      fin_kind = cmsc_pkg::KIND_PREFIX;
    end else if (fws_d) begin
      fin_kind = cmsc_pkg::KIND_WORD;
    end else if (fany_d) begin
      fin_kind = cmsc_pkg::KIND_ANY;
    end else if ((elen != '0) && (sidx_d >= elen)) begin
      fin_kind = cmsc_pkg::KIND_SUBSEQ;
    end else begin
      fin_kind = cmsc_pkg::KIND_NONE;
    end
  end

  assign fin_span = last_d - first_d;

  // Per-item state, back to its start values once the item ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q   <= 1'b1;
      asep_q  <= 1'b0;
      fany_q  <= 1'b0;
      fws_q   <= 1'b0;
      len_q   <= '0;
      sidx_q  <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else if (ctrl.clear) begin
      pal_q   <= 1'b1;
      asep_q  <= 1'b0;
      fany_q  <= 1'b0;
      fws_q   <= 1'b0;
      len_q   <= '0;
      sidx_q  <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else begin
      pal_q   <= pal_d;
      asep_q  <= asep_d;
      fany_q  <= fany_d;
      fws_q   <= fws_d;
      len_q   <= len_d;
      sidx_q  <= sidx_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  // Score stages
  cmsc_score #(
    .LEN_W (LW),
    .EL_W  (EW)
  ) u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i && s_axis_tlast_i),
    .in_ready_o  (fin_ready),
    .in_kind_i   (fin_kind),
    .in_len_i    (len_d),
    .in_span_i   (fin_span),
    .in_elen_i   (elen),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_score_o (out_score),
    .out_kind_o  (out_kind),
    .out_cand_o  (out_cand)
  );

  assign m_axis_tdata_o = {out_kind, out_score};
  assign m_axis_tuser_o = out_cand;

  // The end of an item leaves the tracker at its start values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (len_q == '0) && (sidx_q == '0) && pal_q && !fany_q && !fws_q)
    else $error("item state not cleared after the last byte");

  // The length counter saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(ITEM_LEN_MAX))
    else $error("item length beyond its limit");

  // A no-match result carries a zero score and no candidate flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_kind == cmsc_pkg::KIND_NONE)) |-> ((out_score == '0) && !out_cand))
    else $error("no-match result with a non-zero score");

  // Input stalls only while a result is waiting downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a waiting result");

endmodule

[verif/completion_match_scorer_tb.sv]
// Self-checking testbench of the completion match scorer with its own score predictor.
`timescale 1ns / 1ps

module completion_match_scorer_tb;

  // Block sizes as instantiated, and the run length
  localparam int PAT_SLOTS = 16;
  localparam int RUN_CAP   = 255;
  localparam int ITEM_GOAL = 1350;

  // Tier scores
  localparam int EXACT_PTS   = 1000;
  localparam int PREFIX_BASE = 800;
  localparam int WORD_BASE   = 600;
  localparam int ANY_BASE    = 400;
  localparam int SUBSEQ_BASE = 200;
  localparam int GAP_PENALTY = 10;
  localparam int SCORE_FLOOR = -4096;
  localparam int SCORE_CEIL  = 1000;

  // Characters that open a word
  localparam logic [7:0] SPACE_CH = 8'h20;
  localparam logic [7:0] PAREN_CH = 8'h28;

  // Register addresses; index three is not decoded by the block
  localparam logic [1:0]                  UNUSED_IDX    = 2'd3;
  localparam logic [cmsc_pkg::ADDR_W-1:0] ADDR_PAT_LOW  = {cmsc_pkg::REG_PAT_LOW, 3'b000};
  localparam logic [cmsc_pkg::ADDR_W-1:0] ADDR_PAT_HIGH = {cmsc_pkg::REG_PAT_HIGH, 3'b000};
  localparam logic [cmsc_pkg::ADDR_W-1:0] ADDR_PAT_LEN  = {cmsc_pkg::REG_PAT_LEN, 3'b000};
  localparam logic [cmsc_pkg::ADDR_W-1:0] ADDR_UNUSED   = {UNUSED_IDX, 3'b000};

  typedef struct packed {
    logic signed [12:0]    score;
    cmsc_pkg::match_kind_e kind;
    logic                  cand;
  } score_t;

  localparam score_t NO_SCORE = '{13'sd0, cmsc_pkg::KIND_NONE, 1'b0};

  typedef enum logic {ROW_CHAR, ROW_WRITE} row_op_e;

  typedef struct packed {
    row_op_e                     op;
    logic [cmsc_pkg::ADDR_W-1:0] addr;
    logic [63:0]                 wdata;
    logic [7:0]                  ch;
    logic                        present;
    logic                        last;
    logic                        typed;
    score_t                      want;
  } stim_row_t;

  // Directed stimulus: fixed scores only where they are obvious
  localparam stim_row_t DIRECTED [31] = '{
    // Empty pattern: an empty candidate is exact, an idle step is ignored, any byte is prefix
    '{ROW_CHAR, '0, '0, 8'h00, 1'b0, 1'b1, 1'b1, '{13'sd1000, cmsc_pkg::KIND_EXACT, 1'b1}},
    '{ROW_CHAR, '0, '0, 8'h5A, 1'b0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h61, 1'b1, 1'b1, 1'b1, '{13'sd799, cmsc_pkg::KIND_PREFIX, 1'b1}},
    // Pattern "aBc"
    '{ROW_WRITE, ADDR_PAT_LOW, 64'h0000_0000_0063_4261, 8'h00, 1'b0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_WRITE, ADDR_PAT_LEN, 64'd3, 8'h00, 1'b0, 1'b0, 1'b0, NO_SCORE},
    // "AbC" is exact after case folding
    '{ROW_CHAR, '0, '0, 8'h41, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h62, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h43, 1'b1, 1'b1, 1'b1, '{13'sd1000, cmsc_pkg::KIND_EXACT, 1'b1}},
    // "aBCd" is a prefix match
    '{ROW_CHAR, '0, '0, 8'h61, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h42, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h43, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h64, 1'b1, 1'b1, 1'b1, '{13'sd796, cmsc_pkg::KIND_PREFIX, 1'b1}},
    // "(abc" starts a word
    '{ROW_CHAR, '0, '0, 8'h28, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h61, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h62, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h63, 1'b1, 1'b1, 1'b0, NO_SCORE},
    // "xABc" contains the pattern
    '{ROW_CHAR, '0, '0, 8'h78, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h41, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h42, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h63, 1'b1, 1'b1, 1'b0, NO_SCORE},
    // Subsequence with the extreme bytes in the gaps
    '{ROW_CHAR, '0, '0, 8'h61, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'hFF, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h62, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h00, 1'b1, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'h63, 1'b1, 1'b1, 1'b0, NO_SCORE},
    // No match at all
    '{ROW_CHAR, '0, '0, 8'h71, 1'b1, 1'b1, 1'b1, '{13'sd0, cmsc_pkg::KIND_NONE, 1'b0}},
    // Full pattern registers, length beyond the limit, and a write to an unused address
    '{ROW_WRITE, ADDR_PAT_LOW, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_WRITE, ADDR_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_WRITE, ADDR_PAT_LEN, 64'd31, 8'h00, 1'b0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_WRITE, ADDR_UNUSED, 64'd5, 8'h00, 1'b0, 1'b0, 1'b0, NO_SCORE},
    '{ROW_CHAR, '0, '0, 8'hFF, 1'b1, 1'b1, 1'b1, '{13'sd0, cmsc_pkg::KIND_NONE, 1'b0}}
  };

  // Clock, reset and block ports
  logic                        clk_i           = 1'b0;
  logic                        rst_ni          = 1'b0;
  logic                        s_axis_tvalid_i = 1'b0;
  logic                        s_axis_tready_o;
  logic [7:0]                  s_axis_tdata_i  = '0;  // [7:0] item_char
  logic [0:0]                  s_axis_tuser_i  = '0;  // [0] char_present
  logic                        s_axis_tlast_i  = 1'b0;
  logic                        m_axis_tvalid_o;
  logic                        m_axis_tready_i = 1'b0;
  logic [15:0]                 m_axis_tdata_o;        // [12:0] match_score, [15:13] match_kind
  logic [0:0]                  m_axis_tuser_o;        // [0] is_candidate
  logic                        psel_i          = 1'b0;
  logic                        penable_i       = 1'b0;
  logic                        pwrite_i        = 1'b0;
  logic [cmsc_pkg::ADDR_W-1:0] paddr_i         = '0;
  logic [cmsc_pkg::CFG_W-1:0]  pwdata_i        = '0;
  logic [cmsc_pkg::CFG_W-1:0]  prdata_o;
  logic                        pready_o;

  // Predictor copy of the registers and of the per-candidate state
  logic [63:0] pat_lo  = '0;
  logic [63:0] pat_hi  = '0;
  logic [4:0]  pat_len = '0;
  logic [15:0] run_vec  = '0;
  logic [15:0] word_vec = '0;
  bit prefix_ok      = 1'b1;
  bit sep_seen       = 1'b0;
  bit contained      = 1'b0;
  bit word_contained = 1'b0;
  int run_len     = 0;
  int chase_idx   = 0;
  int chase_first = 0;
  int chase_last  = 0;

  score_t pending_scores[$];
  int     mismatches     = 0;
  int     items_sent     = 0;
  int     send_gap_pct   = 8;
  int     recv_stall_pct = 49;

  completion_match_scorer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always #1 clk_i = ~clk_i;

  // Case folding: only a-z change
  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) return c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pat_raw(input int j);
    if (j < 8) return pat_lo[8*j +: 8];
    if (j < 16) return pat_hi[8*(j-8) +: 8];
    return 8'h00;
  endfunction

  function automatic int active_len();
    int n;
    n = int'(pat_len);
    if (n > PAT_SLOTS) n = PAT_SLOTS;
    return n;
  endfunction

  // Steps the predictor by one item; returns 1 with the score when the candidate ends
  function automatic bit score_char(input logic [7:0] raw, input bit present, input bit last,
                                    output score_t res);
    logic [7:0]            c;
    logic [15:0]           hits;
    int                    n;
    int                    j;
    int                    gap;
    int                    sc;
    cmsc_pkg::match_kind_e k;
    n   = active_len();
    res = NO_SCORE;
    if (present) begin
      c    = upcase(raw);
      hits = '0;
      for (j = 0; j < n; j++) begin
        if (upcase(pat_raw(j)) == c) hits[j] = 1'b1;
      end
      run_vec  = ((run_vec << 1) | 16'd1) & hits;
      word_vec = ((word_vec << 1) | {15'd0, sep_seen}) & hits;
      if (n > 0) begin
        if (run_vec[n-1]) contained = 1'b1;
        if (word_vec[n-1]) word_contained = 1'b1;
      end
      if (run_len < n && upcase(pat_raw(run_len)) != c) prefix_ok = 1'b0;
      if (chase_idx < n && upcase(pat_raw(chase_idx)) == c) begin
        if (chase_idx == 0) chase_first = run_len;
        chase_last = run_len;
        chase_idx++;
      end
      sep_seen = (c == SPACE_CH || c == PAREN_CH);
      if (run_len < RUN_CAP) run_len++;
    end
    if (!last) return 1'b0;

    // Tiers in priority order
    if (prefix_ok && run_len == n) begin
      sc = EXACT_PTS;
      k  = cmsc_pkg::KIND_EXACT;
    end else if (prefix_ok && run_len >= n) begin
      sc = PREFIX_BASE - run_len;
      k  = cmsc_pkg::KIND_PREFIX;
    end else if (word_contained) begin
      sc = WORD_BASE - run_len;
      k  = cmsc_pkg::KIND_WORD;
    end else if (contained) begin
      sc = ANY_BASE - run_len;
      k  = cmsc_pkg::KIND_ANY;
    end else if (n > 0 && chase_idx >= n) begin
      gap = chase_last - chase_first - (n - 1);
      if (gap < 0) gap = 0;
      sc = SUBSEQ_BASE - gap * GAP_PENALTY - run_len;
      k  = cmsc_pkg::KIND_SUBSEQ;
    end else begin
      sc = 0;
      k  = cmsc_pkg::KIND_NONE;
    end
    if (sc < SCORE_FLOOR) sc = SCORE_FLOOR;
    if (sc > SCORE_CEIL) sc = SCORE_CEIL;
    res.score = sc[12:0];
    res.kind  = k;
    res.cand  = (sc > 0);

    // The candidate is finished, so its state starts afresh
    run_vec        = '0;
    word_vec       = '0;
    prefix_ok      = 1'b1;
    sep_seen       = 1'b0;
    contained      = 1'b0;
    word_contained = 1'b0;
    run_len        = 0;
    chase_idx      = 0;
    chase_first    = 0;
    chase_last     = 0;
    return 1'b1;
  endfunction

  function automatic void apply_write(input logic [cmsc_pkg::ADDR_W-1:0] addr,
                                      input logic [63:0] data);
    case (addr[4:3])
      cmsc_pkg::REG_PAT_LOW:  pat_lo = data;
      cmsc_pkg::REG_PAT_HIGH: pat_hi = data;
      cmsc_pkg::REG_PAT_LEN:  pat_len = data[4:0];
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Offers one item, with random gaps ahead of it, and predicts its score once taken
  task automatic push_char(input logic [7:0] ch, input logic present, input logic last,
                           input logic typed, input score_t typed_want);
    score_t got;
    bit     has;
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i   <= 1'b1;
    s_axis_tdata_i    <= ch;
    s_axis_tuser_i[0] <= present;
    s_axis_tlast_i    <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    has = score_char(ch, present, last, got);
    if (has) pending_scores.push_back(typed ? typed_want : got);
    if (present || last) items_sent++;
  endtask

  // Holds the input back until every score has arrived and the pipeline is empty
  task automatic await_scores();
    s_axis_tvalid_i <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cmsc_pkg::ADDR_W-1:0] addr, input logic [63:0] data);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= addr;
    pwdata_i  <= data;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    apply_write(addr, data);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(1))
      return c ^ 8'h20;
    return c;
  endfunction

  // Small alphabet so that random strings still hit the pattern now and then
  function automatic logic [7:0] alphabet_char();
    case ($urandom_range(6)) inside
      [0:2]:   return flip_case(8'h41 + 8'($urandom_range(3)));
      3:       return SPACE_CH;
      4:       return PAREN_CH;
      5:       return flip_case(8'h58);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] filler_char();
    if (active_len() > 0 && $urandom_range(2) == 0)
      return flip_case(pat_raw($urandom_range(active_len() - 1)));
    return alphabet_char();
  endfunction

  // New pattern; short lengths dominate so that partial matches are common
  task automatic load_pattern();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  plen;
    int          k;
    case ($urandom_range(9))
      0:       plen = 5'd0;
      1:       plen = 5'd16;
      2:       plen = 5'($urandom_range(17, 31));
      3:       plen = 5'($urandom_range(6, 15));
      default: plen = 5'($urandom_range(1, 5));
    endcase
    for (k = 0; k < 8; k++) begin
      lo[8*k +: 8] = alphabet_char();
      hi[8*k +: 8] = alphabet_char();
    end
    if ($urandom_range(7) == 0) lo = {$urandom(), $urandom()};
    if ($urandom_range(7) == 0) hi = {$urandom(), $urandom()};
    await_scores();
    write_reg(ADDR_PAT_LOW, lo);
    write_reg(ADDR_PAT_HIGH, hi);
    write_reg(ADDR_PAT_LEN, {59'd0, plen});
    if ($urandom_range(3) == 0) write_reg(ADDR_UNUSED, {$urandom(), $urandom()});
  endtask

  // One candidate string, mostly shaped around the pattern
  task automatic send_candidate();
    logic [7:0] body[$];
    logic [7:0] pat_copy[$];
    int         k;
    bit         tail_mark;
    for (k = 0; k < active_len(); k++) pat_copy.push_back(flip_case(pat_raw(k)));
    case ($urandom_range(15)) inside
      0: body = pat_copy;
      [1:2]: begin
        body = pat_copy;
        repeat ($urandom_range(1, 6)) body.push_back(filler_char());
      end
      [3:4]: begin
        repeat ($urandom_range(4)) body.push_back(filler_char());
        body.push_back($urandom_range(1) ? SPACE_CH : PAREN_CH);
        body = {body, pat_copy};
        repeat ($urandom_range(3)) body.push_back(filler_char());
      end
      [5:6]: begin
        repeat ($urandom_range(1, 5)) body.push_back(filler_char());
        body = {body, pat_copy};
        repeat ($urandom_range(3)) body.push_back(filler_char());
      end
      [7:9]: begin
        foreach (pat_copy[i]) begin
          repeat ($urandom_range(3)) body.push_back(filler_char());
          body.push_back(pat_copy[i]);
        end
        repeat ($urandom_range(2)) body.push_back(filler_char());
      end
      10: ;
      11: begin
        // Now and then a string long enough to saturate the length counter
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(200, 290)) body.push_back(filler_char());
          body = {body, pat_copy};
        end else begin
          repeat ($urandom_range(1, 3)) body.push_back(filler_char());
        end
      end
      default: repeat ($urandom_range(1, 12)) body.push_back(filler_char());
    endcase

    if (body.size() == 0) begin
      push_char(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NO_SCORE);
    end else begin
      tail_mark = ($urandom_range(7) == 0);
      foreach (body[i]) begin
        if ($urandom_range(24) == 0) push_char(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NO_SCORE);
        push_char(body[i], 1'b1, !tail_mark && (i == body.size() - 1), 1'b0, NO_SCORE);
      end
      if (tail_mark) push_char(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NO_SCORE);
    end
  endtask

  // Score side: random back-pressure and comparison with the oldest prediction
  always @(posedge clk_i) begin : take_scores
    score_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_scores.size() == 0) begin
        note_mismatch("score arrived with no candidate pending");
      end else begin
        want = pending_scores.pop_front();
        if (m_axis_tdata_o[12:0] !== want.score)
          note_mismatch($sformatf("match_score %0d, expected %0d",
                                  $signed(m_axis_tdata_o[12:0]), want.score));
        if (m_axis_tdata_o[15:13] !== want.kind)
          note_mismatch($sformatf("match_kind %0d, expected %0d",
                                  m_axis_tdata_o[15:13], want.kind));
        if (m_axis_tuser_o[0] !== want.cand)
          note_mismatch($sformatf("is_candidate %0b, expected %0b",
                                  m_axis_tuser_o[0], want.cand));
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Main sequence: reset, directed table, then three idling regimes of random candidates
  initial begin : stimulus
    int phase;
    int reloads_left;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].op == ROW_WRITE) begin
        await_scores();
        write_reg(DIRECTED[r].addr, DIRECTED[r].wdata);
      end else begin
        push_char(DIRECTED[r].ch, DIRECTED[r].present, DIRECTED[r].last,
                  DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   = 8;
          recv_stall_pct = 49;
        end
        1: begin
          send_gap_pct   = 49;
          recv_stall_pct = 8;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      reloads_left = 0;
      while (items_sent < ITEM_GOAL * (phase + 1) / 3) begin
        if (reloads_left == 0) begin
          load_pattern();
          reloads_left = $urandom_range(4, 16);
        end
        send_candidate();
        reloads_left--;
      end
    end

    await_scores();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run
  initial begin : watchdog
    #500000;
    $display("Mismatches found");
    $finish;
  end

endmodule
